@@ sv/qrr_pkg.sv @@
`timescale 1ns / 1ps

package qrr_pkg;

    // result width and status codes
    localparam int ROOT_WIDTH = 32;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_A_ZERO    = 2'd1;
    localparam status_t ST_DISC_NPOS = 2'd2;

    // saturation limits for a signed 32-bit root
    localparam logic [ROOT_WIDTH-1:0] ROOT_MAX_POS = 32'h7FFF_FFFF;
    localparam logic [ROOT_WIDTH-1:0] ROOT_MIN_NEG = 32'h8000_0000;

endpackage

@@ sv/qrr_sqrt_pipe.sv @@
`timescale 1ns / 1ps

module qrr_sqrt_pipe #(
    parameter int RW  = 33,
    parameter int SBW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [RW-1:0]     out_root,
    output logic [SBW-1:0]    out_sb
);

    // one root bit per stage, restoring digit recurrence
    logic              v_reg    [RW];
    logic [2*RW-1:0]   x_reg    [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SBW-1:0]    sb_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic              v_src;
        logic [2*RW-1:0]   x_src;
        logic [RW+1:0]     rem_src;
        logic [RW-1:0]     root_src;
        logic [SBW-1:0]    sb_src;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic              take;
        logic [RW+1:0]     rem_next;
        logic [RW-1:0]     root_next;

        if (k == 0) begin : g_first
            assign v_src    = in_valid;
            assign x_src    = in_rad;
            assign rem_src  = '0;
            assign root_src = '0;
            assign sb_src   = in_sb;
        end
        else begin : g_rest
            assign v_src    = v_reg[k-1];
            assign x_src    = x_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign sb_src   = sb_reg[k-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_sh    = {rem_src[RW-1:0], x_src[2*RW-1 -: 2]};
        assign trial     = {root_src, 2'b01};
        assign take      = (rem_sh >= trial);
        assign rem_next  = take ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_src[RW-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= {x_src[2*RW-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                sb_reg[k]   <= sb_src;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_sb    = sb_reg[RW-1];

endmodule

@@ sv/qrr_div_pipe.sv @@
`timescale 1ns / 1ps

module qrr_div_pipe #(
    parameter int NW  = 35,
    parameter int DW  = 17,
    parameter int SBW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_num,
    input  logic [DW-1:0]     in_den,
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [NW-1:0]     out_quo,
    output logic [SBW-1:0]    out_sb
);

    // one quotient bit per stage, restoring division of magnitudes
    logic              v_reg   [NW];
    logic [NW-1:0]     n_reg   [NW];
    logic [NW-1:0]     q_reg   [NW];
    logic [DW:0]       rem_reg [NW];
    logic [DW-1:0]     d_reg   [NW];
    logic [SBW-1:0]    sb_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic              v_src;
        logic [NW-1:0]     n_src;
        logic [NW-1:0]     q_src;
        logic [DW:0]       rem_src;
        logic [DW-1:0]     d_src;
        logic [SBW-1:0]    sb_src;
        logic [DW:0]       rem_sh;
        logic              take;

        if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign n_src   = in_num;
            assign q_src   = '0;
            assign rem_src = '0;
            assign d_src   = in_den;
            assign sb_src  = in_sb;
        end
        else begin : g_rest
            assign v_src   = v_reg[k-1];
            assign n_src   = n_reg[k-1];
            assign q_src   = q_reg[k-1];
            assign rem_src = rem_reg[k-1];
            assign d_src   = d_reg[k-1];
            assign sb_src  = sb_reg[k-1];
        end

        // shift in the next numerator bit and subtract when it fits
        assign rem_sh = {rem_src[DW-1:0], n_src[NW-1]};
        assign take   = (rem_sh >= {1'b0, d_src});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= {n_src[NW-2:0], 1'b0};
                q_reg[k]   <= {q_src[NW-2:0], take};
                rem_reg[k] <= take ? (rem_sh - {1'b0, d_src}) : rem_sh;
                d_reg[k]   <= d_src;
                sb_reg[k]  <= sb_src;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_quo   = q_reg[NW-1];
    assign out_sb    = sb_reg[NW-1];

endmodule

@@ sv/quadratic_real_roots_core.sv @@
`timescale 1ns / 1ps

// Real roots of a*x^2 + b*x + c. Coefficients are signed fixed point with
// COEF_WIDTH/2 fraction bits; roots are signed 32-bit with ROOT_FRAC_BITS
// fraction bits, truncated toward zero and saturated. One request is taken
// every clock cycle unless stalled. Stage 1 (products), stage 2 (discriminant),
// RW square-root stages (one root bit each, (2*COEF_WIDTH+1+2*ROOT_FRAC_BITS+1)/2),
// stage 3 (numerators), NW divider stages (one quotient bit each, the width of
// the signed numerator) and the output register follow in order. When the
// output holds a result and is stalled, the whole pipeline holds and in_stall
// rises. status reports a zero a or a non-positive discriminant; the roots then read zero.
module quadratic_real_roots_core
    import qrr_pkg::*;
#(
    parameter int COEF_WIDTH     = 16,
    parameter int ROOT_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [ROOT_WIDTH-1:0] root_plus,
    output logic signed [ROOT_WIDTH-1:0] root_minus,
    output logic [1:0]                   status,
    output logic                         saturated
);

    localparam int W    = COEF_WIDTH;
    localparam int F    = ROOT_FRAC_BITS;
    localparam int DW   = 2*W + 1;
    localparam int XW   = DW + 2*F;
    localparam int RW   = (XW + 1) / 2;
    localparam int SNW  = W + 1 + F;
    localparam int NWS  = ((SNW > RW + 1) ? SNW : RW + 1) + 1;
    localparam int DNW  = W + 1;
    localparam int CW   = (NWS > ROOT_WIDTH + 1) ? NWS : ROOT_WIDTH + 1;
    localparam int SBW  = 2 + SNW + W;

    // whole pipeline moves unless a finished result is held
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // stage 1: products
    logic                    v1_reg;
    logic signed [W-1:0]     a1_reg;
    logic signed [W-1:0]     b1_reg;
    logic signed [2*W-1:0]   ac1_reg;
    logic signed [2*W-1:0]   bb1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            ac1_reg <= coef_a * coef_c;
            bb1_reg <= coef_b * coef_b;
        end
    end

    // stage 2: discriminant, status, scaled -b
    logic [2*W-1:0]          ac_mag;
    logic [DW-1:0]           four_ac;
    logic [DW-1:0]           bb_u;
    logic [DW-1:0]           disc_sum;
    logic [DW:0]             disc_diff;
    logic [DW-1:0]           disc;
    logic                    disc_pos;
    status_t                 status_next;
    logic signed [SNW-1:0]   snb_next;

    always_comb
    begin
        ac_mag    = ac1_reg[2*W-1] ? (-ac1_reg) : ac1_reg;
        four_ac   = {ac_mag[2*W-2:0], 2'b00};
        bb_u      = {1'b0, bb1_reg};
        disc_sum  = bb_u + four_ac;
        disc_diff = {1'b0, bb_u} - {1'b0, four_ac};
        if (ac1_reg[2*W-1] || (ac1_reg == '0))
        begin
            disc     = disc_sum;
            disc_pos = (disc_sum != '0);
        end
        else
        begin
            disc     = disc_diff[DW-1:0];
            disc_pos = !disc_diff[DW] && (disc_diff != '0);
        end
        if (a1_reg == '0)
        begin
            status_next = ST_A_ZERO;
        end
        else if (!disc_pos)
        begin
            status_next = ST_DISC_NPOS;
        end
        else
        begin
            status_next = ST_OK;
        end
        snb_next = -{b1_reg[W-1], b1_reg, {F{1'b0}}};
    end

    logic                    v2_reg;
    logic [2*RW-1:0]         rad2_reg;
    logic [SBW-1:0]          sb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad2_reg <= (2*RW)'({disc, {(2*F){1'b0}}});
            sb2_reg  <= {status_next, snb_next, a1_reg};
        end
    end

    // square root pipeline
    logic              sq_valid;
    logic [RW-1:0]     sq_root;
    logic [SBW-1:0]    sq_sb;

    qrr_sqrt_pipe #(
        .RW  (RW),
        .SBW (SBW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v2_reg),
        .in_rad    (rad2_reg),
        .in_sb     (sb2_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    // stage 3: numerators and divisor magnitudes
    status_t                 sq_status;
    logic signed [SNW-1:0]   sq_snb;
    logic signed [W-1:0]     sq_a;
    logic signed [NWS-1:0]   snb_x;
    logic signed [NWS-1:0]   s_x;
    logic signed [NWS-1:0]   num_p;
    logic signed [NWS-1:0]   num_m;
    logic [W-1:0]            a_mag;

    always_comb
    begin
        {sq_status, sq_snb, sq_a} = sq_sb;
        snb_x = NWS'(sq_snb);
        s_x   = NWS'(sq_root);
        num_p = snb_x + s_x;
        num_m = snb_x - s_x;
        a_mag = sq_a[W-1] ? (-sq_a) : sq_a;
    end

    logic              v3_reg;
    logic [NWS-1:0]    mp3_reg;
    logic [NWS-1:0]    mm3_reg;
    logic              np3_reg;
    logic              nm3_reg;
    logic [DNW-1:0]    den3_reg;
    status_t           st3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mp3_reg  <= num_p[NWS-1] ? (-num_p) : num_p;
            mm3_reg  <= num_m[NWS-1] ? (-num_m) : num_m;
            np3_reg  <= num_p[NWS-1] ^ sq_a[W-1];
            nm3_reg  <= num_m[NWS-1] ^ sq_a[W-1];
            den3_reg <= {a_mag, 1'b0};
            st3_reg  <= sq_status;
        end
    end

    // divider pipelines, one for each root
    logic              dp_valid;
    logic [NWS-1:0]    dp_quo;
    logic [2:0]        dp_sb;
    logic              dm_valid;
    logic [NWS-1:0]    dm_quo;
    logic              dm_neg;

    qrr_div_pipe #(
        .NW  (NWS),
        .DW  (DNW),
        .SBW (3)
    ) u_div_plus (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (mp3_reg),
        .in_den    (den3_reg),
        .in_sb     ({st3_reg, np3_reg}),
        .out_valid (dp_valid),
        .out_quo   (dp_quo),
        .out_sb    (dp_sb)
    );

    qrr_div_pipe #(
        .NW  (NWS),
        .DW  (DNW),
        .SBW (1)
    ) u_div_minus (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_num    (mm3_reg),
        .in_den    (den3_reg),
        .in_sb     (nm3_reg),
        .out_valid (dm_valid),
        .out_quo   (dm_quo),
        .out_sb    (dm_neg)
    );

    // sign and saturate, blank on failure
    logic [CW-1:0]           qp_x;
    logic [CW-1:0]           qm_x;
    logic                    sat_p;
    logic                    sat_m;
    logic [ROOT_WIDTH-1:0]   rp_next;
    logic [ROOT_WIDTH-1:0]   rm_next;
    logic                    sat_next;
    status_t                 st_fin;

    always_comb
    begin
        st_fin = dp_sb[2:1];
        qp_x   = CW'(dp_quo);
        qm_x   = CW'(dm_quo);
        if (dp_sb[0])
        begin
            sat_p   = (qp_x > CW'(ROOT_MIN_NEG));
            rp_next = sat_p ? ROOT_MIN_NEG : (-qp_x[ROOT_WIDTH-1:0]);
        end
        else
        begin
            sat_p   = (qp_x > CW'(ROOT_MAX_POS));
            rp_next = sat_p ? ROOT_MAX_POS : qp_x[ROOT_WIDTH-1:0];
        end
        if (dm_neg)
        begin
            sat_m   = (qm_x > CW'(ROOT_MIN_NEG));
            rm_next = sat_m ? ROOT_MIN_NEG : (-qm_x[ROOT_WIDTH-1:0]);
        end
        else
        begin
            sat_m   = (qm_x > CW'(ROOT_MAX_POS));
            rm_next = sat_m ? ROOT_MAX_POS : qm_x[ROOT_WIDTH-1:0];
        end
        sat_next = sat_p || sat_m;
        if (st_fin != ST_OK)
        begin
            rp_next  = '0;
            rm_next  = '0;
            sat_next = 1'b0;
        end
    end

    // output register
    logic                    out_valid_reg;
    logic [ROOT_WIDTH-1:0]   rp_reg;
    logic [ROOT_WIDTH-1:0]   rm_reg;
    status_t                 st_reg;
    logic                    sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_reg  <= rp_next;
            rm_reg  <= rm_next;
            st_reg  <= st_fin;
            sat_reg <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign root_plus  = rp_reg;
    assign root_minus = rm_reg;
    assign status     = st_reg;
    assign saturated  = sat_reg;

    // checks
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dp_valid == dm_valid)
        else $error("divider pipelines out of step");

    a_fail_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (root_plus == '0) && (root_minus == '0) && !saturated)
        else $error("failed request carries non-zero roots");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root_plus)
            && $stable(root_minus) && $stable(status))
        else $error("held result changed under stall");

endmodule

@@ verif/tb_quadratic_real_roots_core.sv @@
`timescale 1ns / 1ps

module tb_quadratic_real_roots_core
    import qrr_pkg::*;
;

    localparam int CW         = 16;
    localparam int FRAC       = 16;
    localparam int N_RANDOM   = 650;
    localparam int IDLE_LIMIT = 20000;
    localparam int LATENCY    = 72;

    typedef struct {
        logic signed [31:0] root_plus;
        logic signed [31:0] root_minus;
        status_t            status;
        logic               saturated;
    } roots_t;

    // expected roots, oldest first
    class roots_scoreboard;
        roots_t pending[$];
        int     errors;
        int     checked;
        int     n_ok;
        int     n_azero;
        int     n_npos;
        int     n_sat;

        // truncating divide, then clip to signed 32 bits
        function automatic logic [31:0] div_clip(logic signed [127:0] num,
                                                 logic signed [127:0] den,
                                                 ref logic sat);
            logic signed [127:0] q;
            q = num / den;
            if (q > 128'sd2147483647) begin
                sat = 1'b1;
                return ROOT_MAX_POS;
            end
            if (q < -128'sd2147483648) begin
                sat = 1'b1;
                return ROOT_MIN_NEG;
            end
            return q[31:0];
        endfunction

        function automatic logic [127:0] floor_sqrt(logic [127:0] x);
            logic [127:0] r;
            logic [127:0] t;
            r = '0;
            for (int i = 63; i >= 0; i--) begin
                t = r | (128'd1 << i);
                if (t * t <= x)
                    r = t;
            end
            return r;
        endfunction

        // note a request the block accepted
        function void note_request(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                   logic signed [CW-1:0] c);
            roots_t               r;
            logic signed [127:0]  disc;
            logic signed [127:0]  s;
            logic signed [127:0]  nb;
            logic                 sat;
            r = '{default: '0};
            sat = 1'b0;
            if (a == 0) begin
                r.status = ST_A_ZERO;
                n_azero++;
            end else begin
                disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
                if (disc <= 0) begin
                    r.status = ST_DISC_NPOS;
                    n_npos++;
                end else begin
                    s  = floor_sqrt(disc << (2 * FRAC));
                    nb = -(128'(b) <<< FRAC);
                    r.root_plus  = div_clip(nb + s, 128'sd2 * 128'(a), sat);
                    r.root_minus = div_clip(nb - s, 128'sd2 * 128'(a), sat);
                    r.status     = ST_OK;
                    r.saturated  = sat;
                    n_ok++;
                    if (sat)
                        n_sat++;
                end
            end
            pending.push_back(r);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(roots_t got);
            roots_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result, nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.root_plus !== e.root_plus) begin
                $error("root_plus expected %0d actual %0d", e.root_plus, got.root_plus);
                errors++;
            end
            if (got.root_minus !== e.root_minus) begin
                $error("root_minus expected %0d actual %0d", e.root_minus, got.root_minus);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.saturated !== e.saturated) begin
                $error("saturated expected %0d actual %0d", e.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [31:0]   root_plus;
    logic signed [31:0]   root_minus;
    logic [1:0]           status;
    logic                 saturated;

    roots_scoreboard sb;
    logic            sending_done;
    logic            long_hold;
    int              idle_cycles;

    quadratic_real_roots_core #(
        .COEF_WIDTH     (CW),
        .ROOT_FRAC_BITS (FRAC)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .root_plus  (root_plus),
        .root_minus (root_minus),
        .status     (status),
        .saturated  (saturated)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        sending_done = 1'b0;
        long_hold = 1'b0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // offer one request, wait until taken
    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'(32767 - $urandom_range(0, 3));
            1: return 16'(-32768 + $urandom_range(0, 3));
            2: return 16'($urandom_range(0, 15)) - 16'sd8;
            3: return 16'($urandom_range(0, 1023)) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // request side
    initial
    begin
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        @(posedge rst_n);
        @(posedge clk);
        // directed: extremes, zero a, zero and negative discriminant, saturation
        send_coefs(16'sd256, -16'sd768, 16'sd512, 0);
        send_coefs(16'sd0, 16'sd100, 16'sd5, 0);
        send_coefs(16'sd0, 16'sd0, 16'sd0, 0);
        send_coefs(16'sd256, 16'sd512, 16'sd256, 0);
        send_coefs(16'sd256, 16'sd0, 16'sd256, 0);
        send_coefs(-16'sd256, 16'sd0, 16'sd256, 0);
        send_coefs(16'sd1, 16'sh7FFF, 16'sd0, 0);
        send_coefs(16'sd1, -16'sh8000, -16'sh8000, 0);
        send_coefs(-16'sd1, -16'sh8000, 16'sh7FFF, 0);
        send_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_coefs(-16'sh8000, -16'sh8000, -16'sh8000, 0);
        send_coefs(-16'sh8000, 16'sh7FFF, 16'sh7FFF, 0);
        send_coefs(16'sh7FFF, -16'sh8000, -16'sh8000, 0);
        send_coefs(16'sd1, 16'sd1, -16'sd1, 0);
        send_coefs(-16'sd1, 16'sd3, 16'sd1, 0);
        send_coefs(16'sd2, 16'sd4, 16'sd2, 0);
        send_coefs(16'sh5555, -16'sh5556, 16'sh2AAA, 0);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            a = rand_coef();
            b = rand_coef();
            c = rand_coef();
            if ($urandom_range(0, 19) == 0)
                a = '0;
            // stretches with back-to-back requests
            send_coefs(a, b, c, ((i / 50) % 3 == 0) ? 0 : $urandom_range(0, 9));
        end
        in_valid <= 1'b0;
        sending_done <= 1'b1;
    end

    // note accepted requests
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(coef_a, coef_b, coef_c);
    end

    // result side: random stall, one long hold to fill the pipeline
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        repeat (30) @(posedge clk);
        long_hold <= 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
        forever
        begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // results and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_result('{root_plus, root_minus, status, saturated});
                idle_cycles <= 0;
            end
            else if (in_valid && !in_stall)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        fork
            begin
                wait (sending_done && sb.pending.size() == 0);
                repeat (LATENCY + 20) @(posedge clk);
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
            end
        join_any
        if (idle_cycles >= IDLE_LIMIT || sb.pending.size() != 0)
        begin
            $display("timeout with %0d results outstanding", sb.pending.size());
            $display("*** FAILED ***");
        end
        else
        begin
            $display("checked %0d results: %0d real pairs (%0d clipped), %0d zero a,",
                     sb.checked, sb.n_ok, sb.n_sat, sb.n_azero);
            $display("%0d with no positive discriminant, incl. a long output hold",
                     sb.n_npos);
            if (sb.errors == 0)
                $display("*** PASSED ***");
            else
                $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
